// ===== sv/tlti_pkg.sv =====
// shared constants, field widths and helpers for the tank level interpolator
`timescale 1ns / 1ps
`default_nettype none

package tlti_pkg;

  // field widths of one input beat and one output beat
  localparam int KIND_W    = 1;
  localparam int TANK_W    = 2;
  localparam int INDEX_W   = 7;
  localparam int CURRENT_W = 16;
  localparam int VOLUME_W  = 16;
  localparam int LEVEL_W   = 16;

  // default table geometry
  localparam int TANKS_DEF  = 4;
  localparam int POINTS_DEF = 120;

  // serial divider geometry: product over current span
  localparam int DIVIDEND_W = CURRENT_W + VOLUME_W;
  localparam int DIVISOR_W  = CURRENT_W;

  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

  localparam logic [CURRENT_W-1:0] ALL_ONES    = 16'hffff;
  localparam logic [LEVEL_W-1:0]   LEVEL_CLAMP = 16'd65000;

  // an all-ones stored value reads as zero
  function automatic logic [CURRENT_W-1:0] norm(input logic [CURRENT_W-1:0] v);
    norm = (v == ALL_ONES) ? '0 : v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tlti_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module tlti_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [tlti_pkg::DIVIDEND_W-1:0] dividend_i,
  input  wire logic [tlti_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output logic [tlti_pkg::DIVIDEND_W-1:0]      quotient_o
);
  import tlti_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== sv/tank_level_table_interpolator_top.sv =====
// a write beat is stored in the cycle it is taken and gives no output beat
// a query reads its tank table one entry a cycle from one synchronous ram,
// then passes through a multiply step, the serial divider and an output step
// reset clears the sequencer and output valid; table ram is undefined until written
`timescale 1ns / 1ps
`default_nettype none

module tank_level_table_interpolator_top #(
  parameter int TANKS  = tlti_pkg::TANKS_DEF,
  parameter int POINTS = tlti_pkg::POINTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [tlti_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [tlti_pkg::TANK_W-1:0]    tank_i,
  input  wire logic [tlti_pkg::INDEX_W-1:0]   index_i,
  input  wire logic [tlti_pkg::CURRENT_W-1:0] current_i,
  input  wire logic [tlti_pkg::VOLUME_W-1:0]  volume_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [tlti_pkg::LEVEL_W-1:0]        level_o
);
  import tlti_pkg::*;

  localparam int DEPTH  = TANKS * POINTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(POINTS);
  localparam int WORD_W = CURRENT_W + VOLUME_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POINTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;

  // table ram: current in the upper half, volume in the lower half
  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;

  logic [ADDR_W-1:0] sel_base;
  logic              in_take;

  logic [ADDR_W-1:0]    base_q;
  logic [PTR_W-1:0]     issue_q, eval_q;
  logic                 rd_vld_q;
  logic [CURRENT_W-1:0] reading_q;
  logic [CURRENT_W-1:0] p1_c_q, p2_c_q, lo_c_q, hi_c_q;
  logic [VOLUME_W-1:0]  p1_v_q, p2_v_q, lo_v_q, hi_v_q;
  logic [DIVIDEND_W-1:0] prod_q;
  logic [DIVISOR_W-1:0]  cspan_q;
  logic [LEVEL_W-1:0]    q_q;
  logic                  div_start_q;
  logic                  out_valid_q;
  logic [LEVEL_W-1:0]    level_q;

  logic [CURRENT_W-1:0] cur_c;
  logic [VOLUME_W-1:0]  cur_v;
  logic                 div_busy, div_done;
  logic [DIVIDEND_W-1:0] div_quot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_take    = in_valid_i && in_ready_o;

  // tanks out of range fall back to tank 0
  assign sel_base = (int'(tank_i) < TANKS) ? ADDR_W'(tank_i) * ADDR_W'(POINTS) : '0;

  assign mem_we   = in_take && (kind_i == KIND_WRITE) && (int'(index_i) < POINTS);
  assign mem_addr = (state_q == ST_IDLE) ? ADDR_W'(sel_base + ADDR_W'(index_i))
                                         : ADDR_W'(base_q + ADDR_W'(issue_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= {current_i, volume_i};
    end
    rd_data_q <= mem_q[mem_addr];
  end

  assign cur_c = norm(rd_data_q[WORD_W-1:VOLUME_W]);
  assign cur_v = norm(rd_data_q[VOLUME_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      issue_q     <= '0;
      eval_q      <= '0;
      rd_vld_q    <= 1'b0;
      reading_q   <= '0;
      p1_c_q      <= '0;
      p1_v_q      <= '0;
      p2_c_q      <= '0;
      p2_v_q      <= '0;
      lo_c_q      <= '0;
      lo_v_q      <= '0;
      hi_c_q      <= '0;
      hi_v_q      <= '0;
      prod_q      <= '0;
      cspan_q     <= '0;
      q_q         <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
    end else begin
      div_start_q <= (state_q == ST_MUL) && (hi_c_q > lo_c_q);
      // the output state reloads the register itself
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take && (kind_i == KIND_QUERY)) begin
            base_q    <= sel_base;
            reading_q <= current_i;
            issue_q   <= '0;
            eval_q    <= '0;
            rd_vld_q  <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld_q <= 1'b1;
          if (issue_q != PTR_LAST) begin
            issue_q <= issue_q + 1'b1;
          end
          if (rd_vld_q) begin
            if (reading_q < cur_c) begin
              // first breakpoint above the reading
              lo_c_q  <= (eval_q == '0) ? '0 : p1_c_q;
              lo_v_q  <= (eval_q == '0) ? '0 : p1_v_q;
              hi_c_q  <= cur_c;
              hi_v_q  <= cur_v;
              state_q <= ST_MUL;
            end else if ((eval_q != '0) && (cur_c == '0)) begin
              // table end: use the pair ending one entry back
              lo_c_q  <= (eval_q == PTR_W'(1)) ? '0 : p2_c_q;
              lo_v_q  <= (eval_q == PTR_W'(1)) ? '0 : p2_v_q;
              hi_c_q  <= p1_c_q;
              hi_v_q  <= p1_v_q;
              state_q <= ST_MUL;
            end else if (eval_q == PTR_LAST) begin
              lo_c_q  <= p1_c_q;
              lo_v_q  <= p1_v_q;
              hi_c_q  <= cur_c;
              hi_v_q  <= cur_v;
              state_q <= ST_MUL;
            end else begin
              p2_c_q <= p1_c_q;
              p2_v_q <= p1_v_q;
              p1_c_q <= cur_c;
              p1_v_q <= cur_v;
              eval_q <= eval_q + 1'b1;
            end
          end
        end
        ST_MUL: begin
          if (hi_c_q > lo_c_q) begin
            prod_q      <= VOLUME_W'(hi_v_q - lo_v_q) * CURRENT_W'(reading_q - lo_c_q);
            cspan_q     <= DIVISOR_W'(hi_c_q - lo_c_q);
            state_q     <= ST_DIV;
          end else begin
            q_q     <= '0;
            state_q <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            q_q     <= (div_quot > DIVIDEND_W'(LEVEL_CLAMP)) ? LEVEL_CLAMP
                                                             : div_quot[LEVEL_W-1:0];
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            level_q     <= LEVEL_W'(lo_v_q + q_q);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  tlti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (prod_q),
    .divisor_i  (cspan_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

`ifndef SYNTHESIS
  // the divider never starts on a zero span
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_q |-> (cspan_q != '0))
    else $error("divider started with zero span");

  // the divider only runs while the sequencer waits on it
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide state");

  // the scan never walks past the last breakpoint
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (int'(eval_q) < POINTS) && (int'(issue_q) < POINTS))
    else $error("scan pointer beyond table");

  // a result is only loaded once the previous one has left
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_valid_q && !out_ready_i |=> (state_q == ST_FIN))
    else $error("result loaded over a pending beat");
`endif

endmodule

`default_nettype wire

// ===== tb/tank_level_table_interpolator_top_tb.sv =====
// self-checking testbench: table writes and level queries against a built-in level predictor
`timescale 1ns / 1ps

module tank_level_table_interpolator_top_tb;

  localparam int NUM_TANKS   = tlti_pkg::TANKS_DEF;
  localparam int NUM_POINTS  = tlti_pkg::POINTS_DEF;
  localparam int PHASE_ITEMS = 205;
  localparam int END_WAIT    = 200;
  localparam int CYCLE_LIMIT = 1000000;
  // percent of cycles the sender idles / the receiver stalls, per phase
  localparam int TX_IDLE[4]  = '{0, 76, 0, 38};
  localparam int RX_STALL[4] = '{0, 0, 76, 38};

  typedef struct {
    logic [tlti_pkg::KIND_W-1:0]    kind;
    logic [tlti_pkg::TANK_W-1:0]    tank;
    logic [tlti_pkg::INDEX_W-1:0]   index;
    logic [tlti_pkg::CURRENT_W-1:0] current;
    logic [tlti_pkg::VOLUME_W-1:0]  volume;
    int                             phase;
    bit                             drain;
  } beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             in_valid   = 1'b0;
  logic [tlti_pkg::KIND_W-1:0]      in_kind    = tlti_pkg::KIND_WRITE;
  logic [tlti_pkg::TANK_W-1:0]      in_tank    = '0;
  logic [tlti_pkg::INDEX_W-1:0]     in_index   = '0;
  logic [tlti_pkg::CURRENT_W-1:0]   in_current = '0;
  logic [tlti_pkg::VOLUME_W-1:0]    in_volume  = '0;
  logic                             out_ready  = 1'b0;
  logic                             in_ready_o;
  logic                             out_valid_o;
  logic [tlti_pkg::LEVEL_W-1:0]     level_o;

  beat_t                            stim_q[$];
  logic [tlti_pkg::LEVEL_W-1:0]     level_exp[$];
  int                               results_owed = 0;
  int                               tx_phase     = 0;
  int                               fail_count   = 0;
  int                               cycle_count  = 0;

  // predictor copy of the calibration tables
  logic [15:0] tbl_cur[NUM_TANKS*NUM_POINTS];
  logic [15:0] tbl_vol[NUM_TANKS*NUM_POINTS];

  // generator shadow, used only to keep queries off never-written entries
  bit          gen_written[NUM_TANKS][NUM_POINTS];
  logic [15:0] gen_cur[NUM_TANKS][NUM_POINTS];
  int          gen_phase = 0;
  bit          gen_drain = 1'b0;
  int          gen_count = 0;

  tank_level_table_interpolator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .kind_i     (in_kind),
    .tank_i     (in_tank),
    .index_i    (in_index),
    .current_i  (in_current),
    .volume_i   (in_volume),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .level_o    (level_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // stored all-ones reads back as zero
  function automatic logic [15:0] as_read(logic [15:0] raw);
    return (raw == tlti_pkg::ALL_ONES) ? 16'd0 : raw;
  endfunction

  function automatic logic [tlti_pkg::LEVEL_W-1:0] calc_level(int t, logic [15:0] rd);
    int          base;
    int          pos;
    bit          done;
    logic [15:0] c, lo_c, hi_c, lo_v, hi_v, vspan, cspan, off;
    logic [31:0] q;
    base = t * NUM_POINTS;
    pos  = 0;
    done = 1'b0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (!done) begin
        c   = as_read(tbl_cur[base+i]);
        pos = i;
        if (rd < c) begin
          done = 1'b1;
        end else if (i > 0 && c == 16'd0) begin
          pos  = i - 1;
          done = 1'b1;
        end
      end
    end
    if (pos < 1) begin
      // reading below the first breakpoint or a one-point table: interpolate from the origin
      lo_c = 16'd0;
      lo_v = 16'd0;
      hi_c = as_read(tbl_cur[base]);
      hi_v = as_read(tbl_vol[base]);
    end else begin
      lo_c = as_read(tbl_cur[base+pos-1]);
      lo_v = as_read(tbl_vol[base+pos-1]);
      hi_c = as_read(tbl_cur[base+pos]);
      hi_v = as_read(tbl_vol[base+pos]);
    end
    q = 32'd0;
    if (hi_c > lo_c) begin
      vspan = hi_v - lo_v;
      cspan = hi_c - lo_c;
      off   = rd - lo_c;
      q     = (32'(vspan) * 32'(off)) / 32'(cspan);
      if (q > 32'(tlti_pkg::LEVEL_CLAMP)) q = 32'(tlti_pkg::LEVEL_CLAMP);
    end
    return lo_v + q[15:0];
  endfunction

  task automatic push_write(int t, int idx, logic [15:0] cur, logic [15:0] vol);
    beat_t b;
    b.kind    = tlti_pkg::KIND_WRITE;
    b.tank    = t[1:0];
    b.index   = idx[6:0];
    b.current = cur;
    b.volume  = vol;
    b.phase   = gen_phase;
    b.drain   = gen_drain;
    gen_drain = 1'b0;
    stim_q.push_back(b);
    if (idx < NUM_POINTS) begin
      gen_written[t][idx] = 1'b1;
      gen_cur[t][idx]     = cur;
      gen_count++;
    end
  endtask

  // first never-written entry a query scan would touch, one past the stop included
  function automatic int unsafe_entry(int t, logic [15:0] rd);
    logic [15:0] c;
    for (int i = 0; i < NUM_POINTS; i++) begin
      if (!gen_written[t][i]) return i;
      c = as_read(gen_cur[t][i]);
      if (rd < c || (i > 0 && c == 16'd0)) begin
        if (i + 1 < NUM_POINTS && !gen_written[t][i+1]) return i + 1;
        return -1;
      end
    end
    return -1;
  endfunction

  task automatic push_query(int t, logic [15:0] rd);
    beat_t b;
    int    gap;
    gap = unsafe_entry(t, rd);
    while (gap >= 0) begin
      if (gap == 0) push_write(t, 0, 16'($urandom), 16'($urandom));
      else push_write(t, gap, ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff,
                      16'($urandom));
      gap = unsafe_entry(t, rd);
    end
    b.kind    = tlti_pkg::KIND_QUERY;
    b.tank    = t[1:0];
    b.index   = 7'($urandom);
    b.current = rd;
    b.volume  = 16'($urandom);
    b.phase   = gen_phase;
    b.drain   = gen_drain;
    gen_drain = 1'b0;
    stim_q.push_back(b);
    gen_count++;
  endtask

  // non-decreasing breakpoint table with an end marker when short of full, then queries around it
  task automatic build_table(int t);
    int          n, c, step, step_max, vacc;
    logic [15:0] vol;
    logic [15:0] rd;
    int          pts[NUM_POINTS];
    n        = ($urandom_range(0, 11) == 0) ? NUM_POINTS : $urandom_range(1, 8);
    step_max = (n == NUM_POINTS) ? 500 : $urandom_range(50, 8000);
    c        = $urandom_range(0, 1500);
    vacc     = $urandom_range(0, 20000);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       vol = 16'hffff;
        1, 2:    vol = 16'($urandom);
        default: begin
          vacc = (vacc + $urandom_range(0, 9000)) % 65536;
          vol  = vacc[15:0];
        end
      endcase
      push_write(t, i, c[15:0], vol);
      pts[i] = c;
      step = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, step_max);
      c    = (c + step > 65534) ? 65534 : c + step;
    end
    if (n < NUM_POINTS) begin
      push_write(t, n, ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff, 16'($urandom));
    end
    repeat ($urandom_range(2, 6)) begin
      case ($urandom_range(0, 5))
        0:       rd = 16'(pts[$urandom_range(0, n-1)]);
        1:       rd = 16'(pts[$urandom_range(0, n-1)] - 1);
        2:       rd = 16'd0;
        3:       rd = 16'hffff;
        default: rd = 16'($urandom_range(0, (c + step_max > 65535) ? 65535 : c + step_max));
      endcase
      push_query(t, rd);
    end
  endtask

  // sender: one beat held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t nxt;
    bit    query_taken;
    bit    present;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      query_taken = in_valid && in_ready_o && (in_kind == tlti_pkg::KIND_QUERY);
      if (!in_valid || in_ready_o) begin
        present = 1'b0;
        if (stim_q.size() != 0) begin
          nxt = stim_q[0];
          if (!(nxt.drain && (results_owed != 0 || query_taken)) &&
              $urandom_range(0, 99) >= TX_IDLE[nxt.phase]) begin
            present = 1'b1;
            void'(stim_q.pop_front());
            in_kind    <= nxt.kind;
            in_tank    <= nxt.tank;
            in_index   <= nxt.index;
            in_current <= nxt.current;
            in_volume  <= nxt.volume;
            tx_phase   <= nxt.phase;
          end
        end
        in_valid <= present;
      end
    end
  end

  // receiver and checker: compare level beats first, then predict from the input beat
  always @(posedge clk_i or negedge rst_ni) begin
    logic [tlti_pkg::LEVEL_W-1:0] want;
    int                           slot;
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      results_owed <= 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (level_exp.size() == 0) begin
          $error("level: expected none, actual %0d", level_o);
          fail_count++;
        end else begin
          want = level_exp.pop_front();
          if (level_o !== want) begin
            $error("level: expected %0d, actual %0d", want, level_o);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        if (in_kind == tlti_pkg::KIND_WRITE) begin
          if (in_index < NUM_POINTS) begin
            slot          = int'(in_tank) * NUM_POINTS + int'(in_index);
            tbl_cur[slot] = in_current;
            tbl_vol[slot] = in_volume;
          end
        end else begin
          level_exp.push_back(calc_level(int'(in_tank), in_current));
        end
      end
      results_owed <= level_exp.size();
      out_ready    <= ($urandom_range(0, 99) >= RX_STALL[tx_phase]);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_TANKS * NUM_POINTS; i++) begin
      tbl_cur[i] = '0;
      tbl_vol[i] = '0;
    end

    // tank 0: origin segment, normal segment, equal currents, all-ones end marker
    push_write(0, 0, 16'd1000, 16'd500);
    push_write(0, 1, 16'd2000, 16'd3000);
    push_write(0, 2, 16'd2000, 16'd4000);
    push_write(0, 3, 16'hffff, 16'd7);
    push_query(0, 16'd0);
    push_query(0, 16'd500);
    push_query(0, 16'd1000);
    push_query(0, 16'd1999);
    push_query(0, 16'd2000);
    push_query(0, 16'hffff);
    // tank 1: steep segment past the end, quotient clamps
    push_write(1, 0, 16'd1, 16'd0);
    push_write(1, 1, 16'd2, 16'd60000);
    push_write(1, 2, 16'd0, 16'hffff);
    push_query(1, 16'hffff);
    // tank 2: clamped quotient wraps the sum
    push_write(2, 0, 16'd100, 16'd40000);
    push_write(2, 1, 16'd200, 16'd50000);
    push_write(2, 2, 16'd0, 16'd0);
    push_query(2, 16'd60000);
    // tank 3: one usable point, all-ones volume, writes beyond the table
    push_write(3, 0, 16'd500, 16'hffff);
    push_write(3, 1, 16'd0, 16'd0);
    push_write(3, 127, 16'd1234, 16'd4321);
    push_write(3, NUM_POINTS, 16'hffff, 16'hffff);
    push_query(3, 16'd250);
    push_query(3, 16'd1000);

    for (int ph = 0; ph < 4; ph++) begin
      gen_phase = ph;
      gen_drain = 1'b1;
      gen_count = 0;
      while (gen_count < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1:    push_write($urandom_range(0, NUM_TANKS-1), $urandom_range(0, 127),
                              16'($urandom), 16'($urandom));
          2:       push_query($urandom_range(0, NUM_TANKS-1), 16'($urandom));
          default: build_table($urandom_range(0, NUM_TANKS-1));
        endcase
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);

    if (level_exp.size() != 0) begin
      $error("level: %0d expected beats never arrived", level_exp.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
